FILE: design/pfa_pkg.sv
// Package for the page frame allocator: sizes, request and status codes,
// and the payload structs of the request, response and register channels.
// No dependencies; every other design file uses it.
package pfa_pkg;

   // Store sizes.
   localparam int NUM_FRAMES = 64;
   localparam int NUM_PROCS  = 64;

   // Widths that follow from the store sizes.
   localparam int FRAME_AW = $clog2(NUM_FRAMES);
   localparam int IDX_W    = $clog2(NUM_FRAMES + 1);

   // Fixed field widths of the channels.
   localparam int PID_W = 6;
   localparam int CNT_W = 7;

   // Request kinds.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Response status codes.
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PID_W-1:0] process_id;
      logic [CNT_W-1:0] page_count;
   } pfa_req_type;

   typedef struct packed {
      logic             status;
      logic [CNT_W-1:0] frames_changed;
      logic [CNT_W-1:0] free_after;
   } pfa_rsp_type;

   typedef logic [CNT_W-1:0] pfa_csr_type;

endpackage

FILE: design/pfa_req_if.sv
// Request channel of the page frame allocator: valid, ready and payload.
// Depends on pfa_pkg for the payload struct.
interface pfa_req_if;
   logic                 valid;
   logic                 ready;
   pfa_pkg::pfa_req_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

FILE: design/pfa_rsp_if.sv
// Response channel of the page frame allocator: valid, ready and payload.
// Depends on pfa_pkg for the payload struct.
interface pfa_rsp_if;
   logic                 valid;
   logic                 ready;
   pfa_pkg::pfa_rsp_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

FILE: design/pfa_csr_if.sv
// Register write channel of the page frame allocator (frame count register).
// Depends on pfa_pkg for the data type.
interface pfa_csr_if;
   logic                 valid;
   logic                 ready;
   pfa_pkg::pfa_csr_type data;

   modport source  (output valid, output data, input ready);
   modport sink    (input valid, input data, output ready);
   modport monitor (input valid, input data, input ready);
endinterface

FILE: design/page_frame_allocator.sv
// Top level of the page frame allocator: first-free frame allocation and
// per-process release over an owner map, one frame visited per cycle.
// Depends on pfa_pkg and the interfaces pfa_req_if, pfa_rsp_if, pfa_csr_if.
//
//   Channel   Direction  Payload                                   Handshake
//   req_if    in         req_type, process_id, page_count          valid/ready
//   rsp_if    out        status, frames_changed, free_after        valid/ready
//   csr_if    in         frame count (7 bits)                      valid/ready
//
// An allocate visits frames from the lowest index up until the request is met, at
// most the active frame count. A free visits every active frame through the owner
// memory read port. Refused, empty and ignored requests skip the scan.
// Reset and a register write clear the frame valid bits at once; the block
// takes one request at a time and accepts the next while a response waits.
module page_frame_allocator (
   input logic        clock,
   input logic        reset,
   pfa_req_if.sink    req_if,
   pfa_rsp_if.source  rsp_if,
   pfa_csr_if.sink    csr_if
);
   import pfa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // Sequencer and request registers.
   state_type           state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [PID_W-1:0]    pid_ff, pid_in;
   logic [CNT_W-1:0]    want_ff, want_in;
   logic                refused_ff, refused_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    changed_ff, changed_in;

   // Read pipeline stage of the release scan.
   logic                pv_ff, pv_in;
   logic [FRAME_AW-1:0] pidx_ff, pidx_in;

   // Frame store: valid bits in flops, owners in a memory.
   logic [NUM_FRAMES-1:0] used_ff, used_in;
   logic [PID_W-1:0]      owner_mem [NUM_FRAMES];
   logic [PID_W-1:0]      owner_rd_ff;
   logic                  owner_we;
   logic [FRAME_AW-1:0]   frame_addr;

   // Counters set by the register.
   logic [IDX_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    free_count_ff, free_count_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   pfa_rsp_type         rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                csr_fire;
   logic                pid_bad;
   logic [CNT_W-1:0]    changed_inc;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   assign req_fire    = req_if.valid && req_if.ready;
   assign csr_fire    = csr_if.valid && csr_if.ready;
   assign pid_bad     = 32'(req_if.data.process_id) >= NUM_PROCS;
   assign frame_addr  = idx_ff[FRAME_AW-1:0];
   // Shared counter increment used by both scans.
   assign changed_inc = changed_ff + CNT_W'(1);

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pid_in        = pid_ff;
      want_in       = want_ff;
      refused_in    = refused_ff;
      idx_in        = idx_ff;
      changed_in    = changed_ff;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      used_in       = used_ff;
      owner_we      = 1'b0;
      limit_in      = limit_ff;
      free_count_in = free_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in    = req_if.data.req_type;
               pid_in     = req_if.data.process_id;
               want_in    = req_if.data.page_count;
               idx_in     = '0;
               changed_in = '0;
               refused_in = !pid_bad && (req_if.data.req_type == REQ_ALLOC) &&
                            (req_if.data.page_count > free_count_ff);
               if (pid_bad || ((req_if.data.req_type == REQ_ALLOC) &&
                   ((req_if.data.page_count == '0) ||
                    (req_if.data.page_count > free_count_ff)))) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (kind_ff == REQ_ALLOC) begin
               // Claim free frames from the lowest index up.
               if ((idx_ff == limit_ff) || (changed_ff == want_ff)) begin
                  state_in = ST_FINISH;
               end else begin
                  if (!used_ff[frame_addr]) begin
                     used_in[frame_addr] = 1'b1;
                     owner_we            = 1'b1;
                     changed_in          = changed_inc;
                  end
                  idx_in = idx_ff + IDX_W'(1);
               end
            end else begin
               // Issue an owner read, then compare its result in the next cycle.
               if (idx_ff != limit_ff) begin
                  pv_in   = 1'b1;
                  pidx_in = frame_addr;
                  idx_in  = idx_ff + IDX_W'(1);
               end
               if (pv_ff && used_ff[pidx_ff] && (owner_rd_ff == pid_ff)) begin
                  used_in[pidx_ff] = 1'b0;
                  changed_in       = changed_inc;
               end
               if ((idx_ff == limit_ff) && !pv_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               if (kind_ff == REQ_ALLOC) begin
                  free_count_in = free_count_ff - changed_ff;
               end else begin
                  free_count_in = free_count_ff + changed_ff;
               end
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = refused_ff ? STATUS_REFUSED : STATUS_DONE;
               rsp_data_in.frames_changed = changed_ff;
               rsp_data_in.free_after     = free_count_in;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write resizes the store and frees every frame.
      if (csr_fire) begin
         if (32'(csr_if.data) > NUM_FRAMES) begin
            limit_in = IDX_W'(NUM_FRAMES);
         end else begin
            limit_in = IDX_W'(csr_if.data);
         end
         used_in       = '0;
         free_count_in = CNT_W'(limit_in);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pv_ff         <= 1'b0;
         used_ff       <= '0;
         limit_ff      <= IDX_W'(NUM_FRAMES);
         free_count_ff <= CNT_W'(NUM_FRAMES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pv_ff         <= pv_in;
         used_ff       <= used_in;
         limit_ff      <= limit_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pid_ff      <= pid_in;
      want_ff     <= want_in;
      refused_ff  <= refused_in;
      idx_ff      <= idx_in;
      changed_ff  <= changed_in;
      pidx_ff     <= pidx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Owner memory: one write and one registered read at the scan address.
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[frame_addr] <= pid_ff;
      end
      owner_rd_ff <= owner_mem[frame_addr];
   end

endmodule

FILE: design/pfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg; it watches the request handshake and the response handshake and payload.
module pfa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pfa_pkg::pfa_rsp_type rsp_data
);
   import pfa_pkg::*;

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // The block is not ready in the cycle after it takes a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one in progress");

   // A refused allocation changes no frames.
   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_REFUSED)) |->
         (rsp_data.frames_changed == '0))
      else $error("refused allocation reports changed frames");

   // The free count never exceeds the frame store size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.free_after) <= NUM_FRAMES))
      else $error("free count above store size");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

FILE: tb/sv/frame_map_checker.sv
`timescale 1ns / 100ps
// Checker for the page frame allocator: watches the request, response and register
// channels, keeps its own frame owner map and compares every response in order.
// Depends on pfa_pkg and the interfaces pfa_req_if, pfa_rsp_if and pfa_csr_if.
module frame_map_checker (
   input  logic       clock,
   input  logic       reset,
   pfa_req_if.monitor req_mon,
   pfa_rsp_if.monitor rsp_mon,
   pfa_csr_if.monitor csr_mon,
   output int         rsp_seen,
   output int         refusals,
   output int         failures
);
   import pfa_pkg::*;

   localparam int SHOWN_LIMIT = 10;

   // Shadow copy of the frame register and the frame store.
   logic [CNT_W-1:0] frame_limit;
   logic             frame_taken  [NUM_FRAMES];
   logic [PID_W-1:0] frame_holder [NUM_FRAMES];
   int               free_frames;

   // Outcomes of accepted requests, oldest first.
   pfa_rsp_type      pending_outcomes [$];
   int               mismatches;

   initial begin
      rsp_seen   = 0;
      refusals   = 0;
      failures   = 0;
      mismatches = 0;
   end

   // Frames that exist: the register value, capped at the store size.
   function automatic int active_span();
      return (frame_limit > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit);
   endfunction

   // Every frame becomes free; used at reset and on each register write.
   function automatic void wipe_frame_map();
      int f;
      for (f = 0; f < NUM_FRAMES; f++) begin
         frame_taken[f]  = 1'b0;
         frame_holder[f] = '0;
      end
      free_frames = active_span();
   endfunction

   // Applies one request to the shadow store and returns the response it causes.
   function automatic pfa_rsp_type apply_request(pfa_req_type rq);
      pfa_rsp_type outcome;
      int          span;
      int          moved;
      int          f;
      span           = active_span();
      moved          = 0;
      outcome.status = STATUS_DONE;
      if (rq.process_id < NUM_PROCS) begin
         if (rq.req_type == REQ_ALLOC) begin
            // Refuse outright when too few frames are free; take lowest frames first.
            if (int'(rq.page_count) > free_frames) begin
               outcome.status = STATUS_REFUSED;
            end else begin
               for (f = 0; f < span && moved < int'(rq.page_count); f++) begin
                  if (!frame_taken[f]) begin
                     frame_taken[f]  = 1'b1;
                     frame_holder[f] = rq.process_id;
                     moved++;
                  end
               end
               free_frames -= moved;
            end
         end else begin
            // Release every frame the process holds; the page count plays no part.
            for (f = 0; f < span; f++) begin
               if (frame_taken[f] && frame_holder[f] == rq.process_id) begin
                  frame_taken[f]  = 1'b0;
                  frame_holder[f] = '0;
                  moved++;
               end
            end
            free_frames += moved;
         end
      end
      outcome.frames_changed = CNT_W'(moved);
      outcome.free_after     = CNT_W'(free_frames);
      return outcome;
   endfunction

   function automatic void flag_mismatch(string msg);
      if (mismatches < SHOWN_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endfunction

   // Sample all three channels at each rising edge.
   always @(posedge clock) begin
      pfa_rsp_type want;
      pfa_rsp_type got;
      if (reset) begin
         frame_limit = 7'd64;
         wipe_frame_map();
         pending_outcomes.delete();
      end else begin
         // A register transaction clears the store.
         if (csr_mon.valid && csr_mon.ready) begin
            frame_limit = csr_mon.data;
            wipe_frame_map();
         end

         // Each response transaction is matched with the oldest outcome.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got      = rsp_mon.data;
            rsp_seen <= rsp_seen + 1;
            if (pending_outcomes.size() == 0) begin
               flag_mismatch($sformatf("response with none expected: status=%0d changed=%0d free=%0d",
                  got.status, got.frames_changed, got.free_after));
            end else begin
               want = pending_outcomes[0];
               pending_outcomes.delete(0);
               if (got.status !== want.status || got.frames_changed !== want.frames_changed ||
                   got.free_after !== want.free_after) begin
                  flag_mismatch($sformatf(
                     "expected status=%0d changed=%0d free=%0d, got status=%0d changed=%0d free=%0d",
                     want.status, want.frames_changed, want.free_after,
                     got.status, got.frames_changed, got.free_after));
               end
            end
         end

         // Each request transaction updates the shadow store at once.
         if (req_mon.valid && req_mon.ready) begin
            want = apply_request(req_mon.data);
            if (want.status == STATUS_REFUSED) begin
               refusals <= refusals + 1;
            end
            pending_outcomes.insert(pending_outcomes.size(), want);
         end
      end
      failures <= mismatches + pending_outcomes.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the page frame allocator testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on pfa_pkg, the three
// channel interfaces, page_frame_allocator and frame_map_checker.
module testbench;
   import pfa_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 80;
   localparam int PHASES      = 11;

   logic clock = 1'b0;
   logic reset;
   logic calm;
   logic hold_wanted;

   int sent_count   = 0;
   int alloc_sent   = 0;
   int free_sent    = 0;
   int settings_run = 0;
   int cycle_count  = 0;
   int rsp_seen;
   int refusals;
   int failures;

   // Frame counts of the random phases: extremes, no frames, above the cap, mid values.
   logic [CNT_W-1:0] frame_settings [PHASES] =
      '{7'd64, 7'd127, 7'd1, 7'd2, 7'd0, 7'd33, 7'd5, 7'd100, 7'd12, 7'd48, 7'd64};

   pfa_req_if req_if ();
   pfa_rsp_if rsp_if ();
   pfa_csr_if csr_if ();

   page_frame_allocator uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   frame_map_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_if),
      .rsp_mon  (rsp_if),
      .csr_mon  (csr_if),
      .rsp_seen (rsp_seen),
      .refusals (refusals),
      .failures (failures)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Response side: random back-pressure, one long hold-off on request.
   initial begin
      int  stall;
      logic hold_done;
      hold_done    = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_if.ready <= 1'b0;
            for (stall = 0; stall < HOLD_CYCLES; stall++) begin
               @(posedge clock);
            end
            hold_done = 1'b1;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 18);
         end
      end
   end

   // Offers one request transaction, with random idle cycles ahead of it.
   task automatic send_request(input logic kind, input logic [PID_W-1:0] pid,
                               input logic [CNT_W-1:0] pages);
      while (!calm && $urandom_range(99) < 18) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= '{req_type: kind, process_id: pid, page_count: pages};
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
      if (kind == REQ_ALLOC) alloc_sent++;
      else free_sent++;
   endtask

   // Holds off new requests until every response has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (rsp_seen != sent_count) @(posedge clock);
   endtask

   // Register transaction, issued only with the block idle.
   task automatic write_frame_count(input logic [CNT_W-1:0] frames);
      drain_results();
      csr_if.valid <= 1'b1;
      csr_if.data  <= frames;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      settings_run++;
   endtask

   // Random traffic biased toward a small set of processes so frees usually hit owners.
   task automatic random_traffic(input int count, input int span, input int pause_at);
      int               n;
      int               r;
      int               top_pages;
      logic             kind;
      logic [PID_W-1:0] pid;
      logic [CNT_W-1:0] pages;
      top_pages = (span < 4) ? 1 : span / 4;
      for (n = 0; n < count; n++) begin
         if (n == pause_at) drain_results();
         kind = ($urandom_range(99) < 30) ? REQ_FREE : REQ_ALLOC;
         pid  = ($urandom_range(99) < 80) ? PID_W'($urandom_range(7)) : PID_W'($urandom_range(63));
         r    = $urandom_range(99);
         if (r < 8)       pages = '0;
         else if (r < 70) pages = CNT_W'($urandom_range(top_pages, 1));
         else if (r < 85) pages = CNT_W'($urandom_range(span));
         else if (r < 93) pages = CNT_W'($urandom_range(NUM_FRAMES));
         else             pages = CNT_W'($urandom_range(127));
         send_request(kind, pid, pages);
      end
   endtask

   // Main stimulus and verdict.
   initial begin
      int p;
      int span;
      reset        = 1'b1;
      calm         = 1'b0;
      hold_wanted  = 1'b0;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      csr_if.valid = 1'b0;
      csr_if.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset frame count of 64.
      send_request(REQ_ALLOC, 6'd0,  7'd0);    // zero pages
      send_request(REQ_ALLOC, 6'd1,  7'd1);
      send_request(REQ_ALLOC, 6'd2,  7'd10);
      send_request(REQ_ALLOC, 6'd1,  7'd3);    // adds to frames already held
      send_request(REQ_FREE,  6'd5,  7'd127);  // owner of nothing, count ignored
      send_request(REQ_FREE,  6'd2,  7'd0);    // opens a hole low in the map
      send_request(REQ_ALLOC, 6'd63, 7'd5);    // fills the hole first
      send_request(REQ_ALLOC, 6'd3,  7'd127);  // above any frame count
      send_request(REQ_ALLOC, 6'd4,  7'd64);   // too few free
      send_request(REQ_FREE,  6'd1,  7'd64);
      send_request(REQ_FREE,  6'd63, 7'd1);
      send_request(REQ_ALLOC, 6'd42, 7'd64);   // whole map
      send_request(REQ_ALLOC, 6'd7,  7'd1);    // nothing free
      send_request(REQ_ALLOC, 6'd7,  7'd0);
      send_request(REQ_FREE,  6'd42, 7'd0);
      send_request(REQ_ALLOC, 6'd21, 7'd63);

      // No frames at all.
      write_frame_count(7'd0);
      send_request(REQ_ALLOC, 6'd9, 7'd1);
      send_request(REQ_ALLOC, 6'd9, 7'd0);
      send_request(REQ_FREE,  6'd9, 7'd0);

      // Register above the cap, then a single frame.
      write_frame_count(7'd127);
      send_request(REQ_ALLOC, 6'd10, 7'd64);
      send_request(REQ_FREE,  6'd10, 7'd0);
      write_frame_count(7'd1);
      send_request(REQ_ALLOC, 6'd11, 7'd2);
      send_request(REQ_ALLOC, 6'd11, 7'd1);
      send_request(REQ_FREE,  6'd11, 7'd0);

      // Random phases, one per frame count.
      frame_settings[PHASES-1] = CNT_W'($urandom_range(64, 1));
      for (p = 0; p < PHASES; p++) begin
         write_frame_count(frame_settings[p]);
         span = (frame_settings[p] > NUM_FRAMES) ? NUM_FRAMES : int'(frame_settings[p]);
         if (p == 1) hold_wanted <= 1'b1;
         if (p == 5) calm <= 1'b1;
         if (p == 6) calm <= 1'b0;
         if (span == 0) random_traffic(20, span, -1);
         else random_traffic(165, span, (p == 6) ? 80 : -1);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d requests (%0d allocate, %0d free), %0d refused, %0d frame counts",
               sent_count, alloc_sent, free_sent, refusals, settings_run);
      $display("summary: %0d responses checked, incl. a long response stall and a mid-phase drain",
               rsp_seen);
      if (failures == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
